// ===== rtl/rlf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and a helper function of the reachability label filter.
// Used by rlf_cmp and reachability_label_filter_unit; depends on nothing else.
package rlf_pkg;

  localparam int NODE_COUNT  = 4096;
  localparam int LABEL_WORDS = 5;

  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int LVL_W       = 13;
  localparam int WORD_W      = 32;
  localparam int FLAG_W      = 2;
  localparam int HASH_W      = 8;
  localparam int LBL_ADDR_W  = $clog2(NODE_COUNT * LABEL_WORDS);
  localparam int LW_IDX_W    = (LABEL_WORDS > 1) ? $clog2(LABEL_WORDS) : 1;
  localparam int STEP_W      = $clog2(2 * LABEL_WORDS + 1);
  localparam int CMP_W       = WORD_W + 1;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * LABEL_WORDS);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int FLAG_SOURCE = 0;
  localparam int FLAG_SINK   = 1;

  localparam logic [3:0] FLD_DOWN      = 4'd0;
  localparam logic [3:0] FLD_UP        = 4'd1;
  localparam logic [3:0] FLD_MAX_OUT   = 4'd2;
  localparam logic [3:0] FLD_IVL_START = 4'd3;
  localparam logic [3:0] FLD_IVL_END   = 4'd4;
  localparam logic [3:0] FLD_FLAGS     = 4'd5;
  localparam logic [3:0] FLD_OUT0      = 4'd6;
  localparam logic [3:0] FLD_IN0       = 4'd11;

  typedef enum logic [1:0] {
    V_UNREACH   = 2'd0,
    V_REACH     = 2'd1,
    V_UNDECIDED = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_CMP,
    ST_LBL,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CS_DOWN,
    CS_UP,
    CS_MAX_OUT,
    CS_END,
    CS_START
  } cmp_step_t;

  typedef struct packed {
    logic              command;
    logic [11:0]       node_a;
    logic [11:0]       node_b;
    logic [3:0]        record_field;
    logic [WORD_W-1:0] write_value;
  } in_word_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [WORD_W-1:0] filtered_total;
  } out_word_t;

  typedef struct packed {
    logic [LVL_W-1:0]  down;
    logic [LVL_W-1:0]  up;
    logic [WORD_W-1:0] max_out;
    logic [LVL_W-1:0]  ivl_start;
    logic [LVL_W-1:0]  ivl_end;
    logic [FLAG_W-1:0] flags;
  } record_t;

  // Label word picked by a hash: bits 7:5 reduced modulo the label length.
  function automatic logic [LW_IDX_W-1:0] hash_word(input logic [HASH_W-1:0] h);
    logic [3:0] r;
    r = {1'b0, h[7:5]};
    for (int i = 0; i < 7; i++) begin
      if (r >= 4'(LABEL_WORDS)) begin
        r = r - 4'(LABEL_WORDS);
      end
    end
    return LW_IDX_W'(r);
  endfunction

endpackage

// ===== rtl/rlf_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for every label store of the filter.
module rlf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rlf_cmp.sv =====
`timescale 1ns / 1ps
// Shared compare unit: picks the operands of one record test and does a signed compare.
// Depends on rlf_pkg.
module rlf_cmp (
  input  rlf_pkg::cmp_step_t step,
  input  rlf_pkg::record_t   a_rec,
  input  rlf_pkg::record_t   b_rec,
  output logic               hit
);

  logic [rlf_pkg::CMP_W-1:0] x;
  logic [rlf_pkg::CMP_W-1:0] y;
  logic                      inv;
  logic                      lt;

  always_comb begin
    x   = '0;
    y   = '0;
    inv = 1'b0;
    case (step)
      rlf_pkg::CS_DOWN: begin
        x   = rlf_pkg::CMP_W'(a_rec.down);
        y   = rlf_pkg::CMP_W'(b_rec.down);
        inv = 1'b1;
      end
      rlf_pkg::CS_UP: begin
        x   = rlf_pkg::CMP_W'(b_rec.up);
        y   = rlf_pkg::CMP_W'(a_rec.up);
        inv = 1'b1;
      end
      rlf_pkg::CS_MAX_OUT: begin
        x = {a_rec.max_out[rlf_pkg::WORD_W-1], a_rec.max_out};
        y = {b_rec.max_out[rlf_pkg::WORD_W-1], b_rec.max_out};
      end
      rlf_pkg::CS_END: begin
        x = rlf_pkg::CMP_W'(a_rec.ivl_end);
        y = rlf_pkg::CMP_W'(b_rec.ivl_end);
      end
      rlf_pkg::CS_START: begin
        x   = rlf_pkg::CMP_W'(b_rec.ivl_start);
        y   = rlf_pkg::CMP_W'(a_rec.ivl_start);
        inv = 1'b1;
      end
      default: begin
        x   = '0;
        y   = '0;
        inv = 1'b0;
      end
    endcase
  end

  assign lt  = $signed(x) < $signed(y);
  assign hit = lt ^ inv;

endmodule

// ===== rtl/reachability_label_filter_unit.sv =====
`timescale 1ns / 1ps
// Top level of the reachability label filter: record and label stores, sequencer and result register.
// Depends on rlf_pkg, rlf_ram and rlf_cmp.
//
// A write word loads one label field of one node. A query word is accepted, then the
// records of both nodes are read in turn through the single read port of the record
// stores, then one shared comparator runs the level, max_out, interval-end and
// interval-start tests in turn. If those do not decide and neither b's source flag nor
// a's sink flag is set, the label phase reads each node's out and in label words through
// the single read port of each label store, one node per cycle. A query of a node to
// itself goes straight to the result. The result is then held until taken, and no new
// word is taken meanwhile.
module reachability_label_filter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rlf_pkg::out_word_t out_data
);

  rlf_pkg::state_t    state_r, state_nxt;
  rlf_pkg::cmp_step_t step_r, step_nxt;
  rlf_pkg::verdict_t  verdict_r, verdict_nxt;
  rlf_pkg::record_t   arec_r, arec_nxt;

  logic [rlf_pkg::NODE_W-1:0]     a_r, a_nxt;
  logic [rlf_pkg::NODE_W-1:0]     b_r, b_nxt;
  logic [rlf_pkg::LBL_ADDR_W-1:0] ba_r, ba_nxt;
  logic [rlf_pkg::LBL_ADDR_W-1:0] bb_r, bb_nxt;
  logic [rlf_pkg::STEP_W-1:0]     k_r, k_nxt;
  logic [rlf_pkg::WORD_W-1:0]     hold_out_r, hold_out_nxt;
  logic [rlf_pkg::WORD_W-1:0]     hold_in_r, hold_in_nxt;
  logic [rlf_pkg::HASH_W-1:0]     hash_out_r, hash_out_nxt;
  logic [rlf_pkg::HASH_W-1:0]     hash_in_r, hash_in_nxt;
  logic                           lfail_r, lfail_nxt;
  logic [rlf_pkg::WORD_W-1:0]     filt_cnt_r, filt_cnt_nxt;

  logic                           in_acc;
  logic                           wr_acc;
  logic                           query_acc;
  logic [rlf_pkg::NODE_W-1:0]     in_a;
  logic [rlf_pkg::NODE_W-1:0]     in_b;
  logic [rlf_pkg::LBL_ADDR_W-1:0] in_base_a;
  logic [rlf_pkg::LBL_ADDR_W-1:0] in_base_b;
  logic [3:0]                     out_w;
  logic [3:0]                     in_w;
  logic                           out_lbl_we;
  logic                           in_lbl_we;
  logic [rlf_pkg::LBL_ADDR_W-1:0] out_lbl_waddr;
  logic [rlf_pkg::LBL_ADDR_W-1:0] in_lbl_waddr;

  logic [rlf_pkg::NODE_W-1:0]     rec_raddr;
  rlf_pkg::record_t               rec_rd;
  logic [rlf_pkg::LBL_ADDR_W-1:0] out_raddr;
  logic [rlf_pkg::LBL_ADDR_W-1:0] in_raddr;
  logic [rlf_pkg::WORD_W-1:0]     out_rdata;
  logic [rlf_pkg::WORD_W-1:0]     in_rdata;

  logic                           cmp_hit;
  logic                           out_hash;
  logic                           in_hash;
  logic [rlf_pkg::LBL_ADDR_W-1:0] lw_i;
  logic                           fail_now;
  logic                           end_block;

  // Input decode and label store writes.
  assign in_acc    = in_valid & in_ready;
  assign wr_acc    = in_acc & (in_data.command == rlf_pkg::CMD_WRITE);
  assign query_acc = in_acc & (in_data.command == rlf_pkg::CMD_QUERY);
  assign in_a      = in_data.node_a[rlf_pkg::NODE_W-1:0];
  assign in_b      = in_data.node_b[rlf_pkg::NODE_W-1:0];
  assign in_base_a = rlf_pkg::LBL_ADDR_W'(in_a) * rlf_pkg::LBL_ADDR_W'(rlf_pkg::LABEL_WORDS);
  assign in_base_b = rlf_pkg::LBL_ADDR_W'(in_b) * rlf_pkg::LBL_ADDR_W'(rlf_pkg::LABEL_WORDS);

  assign out_w = in_data.record_field - rlf_pkg::FLD_OUT0;
  assign in_w  = in_data.record_field - rlf_pkg::FLD_IN0;

  assign out_lbl_we = wr_acc && (in_data.record_field >= rlf_pkg::FLD_OUT0)
                      && (in_data.record_field < rlf_pkg::FLD_IN0)
                      && (out_w < 4'(rlf_pkg::LABEL_WORDS));
  assign in_lbl_we  = wr_acc && (in_data.record_field >= rlf_pkg::FLD_IN0)
                      && (in_w < 4'(rlf_pkg::LABEL_WORDS));
  assign out_lbl_waddr = in_base_a + rlf_pkg::LBL_ADDR_W'(out_w);
  assign in_lbl_waddr  = in_base_a + rlf_pkg::LBL_ADDR_W'(in_w);

  rlf_ram #(.WIDTH(rlf_pkg::LVL_W), .DEPTH(rlf_pkg::NODE_COUNT)) u_down_ram (
    .clk   (clk),
    .we    (wr_acc && (in_data.record_field == rlf_pkg::FLD_DOWN)),
    .waddr (in_a),
    .wdata (in_data.write_value[rlf_pkg::LVL_W-1:0]),
    .raddr (rec_raddr),
    .rdata (rec_rd.down)
  );

  rlf_ram #(.WIDTH(rlf_pkg::LVL_W), .DEPTH(rlf_pkg::NODE_COUNT)) u_up_ram (
    .clk   (clk),
    .we    (wr_acc && (in_data.record_field == rlf_pkg::FLD_UP)),
    .waddr (in_a),
    .wdata (in_data.write_value[rlf_pkg::LVL_W-1:0]),
    .raddr (rec_raddr),
    .rdata (rec_rd.up)
  );

  rlf_ram #(.WIDTH(rlf_pkg::WORD_W), .DEPTH(rlf_pkg::NODE_COUNT)) u_max_out_ram (
    .clk   (clk),
    .we    (wr_acc && (in_data.record_field == rlf_pkg::FLD_MAX_OUT)),
    .waddr (in_a),
    .wdata (in_data.write_value),
    .raddr (rec_raddr),
    .rdata (rec_rd.max_out)
  );

  rlf_ram #(.WIDTH(rlf_pkg::LVL_W), .DEPTH(rlf_pkg::NODE_COUNT)) u_start_ram (
    .clk   (clk),
    .we    (wr_acc && (in_data.record_field == rlf_pkg::FLD_IVL_START)),
    .waddr (in_a),
    .wdata (in_data.write_value[rlf_pkg::LVL_W-1:0]),
    .raddr (rec_raddr),
    .rdata (rec_rd.ivl_start)
  );

  rlf_ram #(.WIDTH(rlf_pkg::LVL_W), .DEPTH(rlf_pkg::NODE_COUNT)) u_end_ram (
    .clk   (clk),
    .we    (wr_acc && (in_data.record_field == rlf_pkg::FLD_IVL_END)),
    .waddr (in_a),
    .wdata (in_data.write_value[rlf_pkg::LVL_W-1:0]),
    .raddr (rec_raddr),
    .rdata (rec_rd.ivl_end)
  );

  rlf_ram #(.WIDTH(rlf_pkg::FLAG_W), .DEPTH(rlf_pkg::NODE_COUNT)) u_flags_ram (
    .clk   (clk),
    .we    (wr_acc && (in_data.record_field == rlf_pkg::FLD_FLAGS)),
    .waddr (in_a),
    .wdata (in_data.write_value[rlf_pkg::FLAG_W-1:0]),
    .raddr (rec_raddr),
    .rdata (rec_rd.flags)
  );

  rlf_ram #(
    .WIDTH (rlf_pkg::WORD_W),
    .DEPTH (rlf_pkg::NODE_COUNT * rlf_pkg::LABEL_WORDS)
  ) u_out_lbl_ram (
    .clk   (clk),
    .we    (out_lbl_we),
    .waddr (out_lbl_waddr),
    .wdata (in_data.write_value),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

  rlf_ram #(
    .WIDTH (rlf_pkg::WORD_W),
    .DEPTH (rlf_pkg::NODE_COUNT * rlf_pkg::LABEL_WORDS)
  ) u_in_lbl_ram (
    .clk   (clk),
    .we    (in_lbl_we),
    .waddr (in_lbl_waddr),
    .wdata (in_data.write_value),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  // The record stores keep reading node b after the a record is captured.
  rlf_cmp u_cmp (
    .step  (step_r),
    .a_rec (arec_r),
    .b_rec (rec_rd),
    .hit   (cmp_hit)
  );

  // Label phase addressing and checks.
  assign out_hash  = rec_rd.flags[rlf_pkg::FLAG_SINK];
  assign in_hash   = arec_r.flags[rlf_pkg::FLAG_SOURCE];
  assign lw_i      = rlf_pkg::LBL_ADDR_W'(k_r[rlf_pkg::STEP_W-1:1]);
  assign end_block = rec_rd.flags[rlf_pkg::FLAG_SOURCE] | arec_r.flags[rlf_pkg::FLAG_SINK];

  always_comb begin
    if (k_r == rlf_pkg::STEP_LAST) begin
      out_raddr = bb_r;
    end else if (out_hash) begin
      out_raddr = (k_r == '0) ? bb_r
                  : ba_r + rlf_pkg::LBL_ADDR_W'(rlf_pkg::hash_word(out_rdata[7:0]));
    end else begin
      out_raddr = k_r[0] ? (bb_r + lw_i) : (ba_r + lw_i);
    end
  end

  always_comb begin
    if (k_r == rlf_pkg::STEP_LAST) begin
      in_raddr = bb_r;
    end else if (in_hash) begin
      in_raddr = (k_r == '0) ? ba_r
                 : bb_r + rlf_pkg::LBL_ADDR_W'(rlf_pkg::hash_word(in_rdata[7:0]));
    end else begin
      in_raddr = k_r[0] ? (bb_r + lw_i) : (ba_r + lw_i);
    end
  end

  always_comb begin
    fail_now = 1'b0;
    if (state_r == rlf_pkg::ST_LBL) begin
      if (out_hash) begin
        if ((k_r == rlf_pkg::STEP_W'(2)) && !out_rdata[hash_out_r[4:0]]) begin
          fail_now = 1'b1;
        end
      end else if ((k_r != '0) && !k_r[0] && ((hold_out_r & out_rdata) != out_rdata)) begin
        fail_now = 1'b1;
      end
      if (in_hash) begin
        if ((k_r == rlf_pkg::STEP_W'(2)) && !in_rdata[hash_in_r[4:0]]) begin
          fail_now = 1'b1;
        end
      end else if ((k_r != '0) && !k_r[0] && ((hold_in_r & in_rdata) != hold_in_r)) begin
        fail_now = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rlf_pkg::ST_IDLE: begin
        if (query_acc) begin
          state_nxt = (in_a == in_b) ? rlf_pkg::ST_DONE : rlf_pkg::ST_RD_A;
        end
      end
      rlf_pkg::ST_RD_A: begin
        state_nxt = rlf_pkg::ST_RD_B;
      end
      rlf_pkg::ST_RD_B: begin
        state_nxt = rlf_pkg::ST_CMP;
      end
      rlf_pkg::ST_CMP: begin
        if (step_r == rlf_pkg::CS_START) begin
          state_nxt = (cmp_hit || end_block) ? rlf_pkg::ST_DONE : rlf_pkg::ST_LBL;
        end else if (cmp_hit) begin
          state_nxt = rlf_pkg::ST_DONE;
        end
      end
      rlf_pkg::ST_LBL: begin
        if (k_r == rlf_pkg::STEP_LAST) begin
          state_nxt = rlf_pkg::ST_DONE;
        end
      end
      rlf_pkg::ST_DONE: begin
        if (out_ready) begin
          state_nxt = rlf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rlf_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshake and record read address.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    rec_raddr = b_r;
    case (state_r)
      rlf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      rlf_pkg::ST_RD_A: begin
        rec_raddr = a_r;
      end
      rlf_pkg::ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        rec_raddr = b_r;
      end
    endcase
  end

  // Datapath registers.
  always_comb begin
    a_nxt        = a_r;
    b_nxt        = b_r;
    ba_nxt       = ba_r;
    bb_nxt       = bb_r;
    arec_nxt     = arec_r;
    step_nxt     = step_r;
    k_nxt        = k_r;
    hold_out_nxt = hold_out_r;
    hold_in_nxt  = hold_in_r;
    hash_out_nxt = hash_out_r;
    hash_in_nxt  = hash_in_r;
    lfail_nxt    = lfail_r;
    verdict_nxt  = verdict_r;
    filt_cnt_nxt = filt_cnt_r;
    case (state_r)
      rlf_pkg::ST_IDLE: begin
        if (query_acc) begin
          a_nxt       = in_a;
          b_nxt       = in_b;
          ba_nxt      = in_base_a;
          bb_nxt      = in_base_b;
          step_nxt    = rlf_pkg::CS_DOWN;
          verdict_nxt = rlf_pkg::V_REACH;
        end
      end
      rlf_pkg::ST_RD_B: begin
        arec_nxt = rec_rd;
      end
      rlf_pkg::ST_CMP: begin
        k_nxt     = '0;
        lfail_nxt = 1'b0;
        if (step_r == rlf_pkg::CS_START) begin
          verdict_nxt = cmp_hit ? rlf_pkg::V_REACH : rlf_pkg::V_UNREACH;
        end else if (cmp_hit) begin
          verdict_nxt  = rlf_pkg::V_UNREACH;
          filt_cnt_nxt = filt_cnt_r + rlf_pkg::WORD_W'(1);
        end else begin
          step_nxt = rlf_pkg::cmp_step_t'(step_r + 3'd1);
        end
      end
      rlf_pkg::ST_LBL: begin
        k_nxt     = k_r + rlf_pkg::STEP_W'(1);
        lfail_nxt = lfail_r | fail_now;
        if (k_r[0]) begin
          hold_out_nxt = out_rdata;
          hold_in_nxt  = in_rdata;
        end
        if (k_r == rlf_pkg::STEP_W'(1)) begin
          hash_out_nxt = out_rdata[rlf_pkg::HASH_W-1:0];
          hash_in_nxt  = in_rdata[rlf_pkg::HASH_W-1:0];
        end
        if (k_r == rlf_pkg::STEP_LAST) begin
          verdict_nxt = (lfail_r | fail_now) ? rlf_pkg::V_UNREACH : rlf_pkg::V_UNDECIDED;
        end
      end
      default: begin
        k_nxt = k_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rlf_pkg::ST_IDLE;
      filt_cnt_r <= '0;
      step_r     <= rlf_pkg::CS_DOWN;
      k_r        <= '0;
      lfail_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      filt_cnt_r <= filt_cnt_nxt;
      step_r     <= step_nxt;
      k_r        <= k_nxt;
      lfail_r    <= lfail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    ba_r       <= ba_nxt;
    bb_r       <= bb_nxt;
    arec_r     <= arec_nxt;
    hold_out_r <= hold_out_nxt;
    hold_in_r  <= hold_in_nxt;
    hash_out_r <= hash_out_nxt;
    hash_in_r  <= hash_in_nxt;
    verdict_r  <= verdict_nxt;
  end

  assign out_data.verdict        = verdict_r;
  assign out_data.filtered_total = filt_cnt_r;

  // The filtered count only ever steps by one, and only out of the compare sequence.
  a_filt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (filt_cnt_r != $past(filt_cnt_r)) |->
      ((filt_cnt_r == $past(filt_cnt_r) + rlf_pkg::WORD_W'(1))
       && ($past(state_r) == rlf_pkg::ST_CMP)))
    else $error("filtered count changed outside a filter rejection");

  // A filter rejection always ends the query with an unreachable result.
  a_filt_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (filt_cnt_r != $past(filt_cnt_r)) |->
      ((state_r == rlf_pkg::ST_DONE) && (verdict_r == rlf_pkg::V_UNREACH)))
    else $error("filter rejection without an unreachable result");

  // The block never takes a new word while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

endmodule

// ===== sim/tb_reachability_label_filter_unit.sv =====
`timescale 1ns / 1ps
// Testbench of reachability_label_filter_unit: loads label records, runs queries under
// varied idling and checks each verdict and filtered total against its own label tables.
// Depends on rlf_pkg and the block's RTL only.
module tb_reachability_label_filter_unit;

  localparam int POOL_SIZE       = 24;
  localparam int WATCHDOG_CYCLES = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  rlf_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rlf_pkg::out_word_t out_data;

  reachability_label_filter_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [rlf_pkg::LVL_W-1:0]  lvl_down    [rlf_pkg::NODE_COUNT];
  logic [rlf_pkg::LVL_W-1:0]  lvl_up      [rlf_pkg::NODE_COUNT];
  logic [rlf_pkg::WORD_W-1:0] max_out_tbl [rlf_pkg::NODE_COUNT];
  logic [rlf_pkg::LVL_W-1:0]  ivl_lo      [rlf_pkg::NODE_COUNT];
  logic [rlf_pkg::LVL_W-1:0]  ivl_hi      [rlf_pkg::NODE_COUNT];
  logic [rlf_pkg::FLAG_W-1:0] flag_tbl    [rlf_pkg::NODE_COUNT];
  logic [rlf_pkg::WORD_W-1:0] out_lbl     [rlf_pkg::NODE_COUNT][rlf_pkg::LABEL_WORDS];
  logic [rlf_pkg::WORD_W-1:0] in_lbl      [rlf_pkg::NODE_COUNT][rlf_pkg::LABEL_WORDS];
  logic [rlf_pkg::WORD_W-1:0] rejected_total = '0;

  rlf_pkg::out_word_t verdict_q[$];
  rlf_pkg::out_word_t verdict_head;
  logic [11:0] pool [POOL_SIZE];
  int unsigned words_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  function automatic int unsigned hash_slot(input logic [7:0] h);
    return (32'(h) >> 5) % rlf_pkg::LABEL_WORDS;
  endfunction

  task automatic resolve_query(input int unsigned a, input int unsigned b,
                               output rlf_pkg::verdict_t v);
    logic [7:0] h;
    v = rlf_pkg::V_UNREACH;
    if (a == b) begin
      v = rlf_pkg::V_REACH;
      return;
    end
    if (lvl_down[a] >= lvl_down[b] || lvl_up[a] <= lvl_up[b] ||
        $signed(max_out_tbl[a]) < $signed(max_out_tbl[b]) || ivl_hi[a] < ivl_hi[b]) begin
      rejected_total++;
      return;
    end
    if (ivl_lo[a] <= ivl_lo[b]) begin
      v = rlf_pkg::V_REACH;
      return;
    end
    if (flag_tbl[b][rlf_pkg::FLAG_SOURCE] || flag_tbl[a][rlf_pkg::FLAG_SINK]) return;
    if (flag_tbl[b][rlf_pkg::FLAG_SINK]) begin
      h = out_lbl[b][0][7:0];
      if (!out_lbl[a][hash_slot(h)][h[4:0]]) return;
    end else begin
      for (int i = 0; i < rlf_pkg::LABEL_WORDS; i++) begin
        if ((out_lbl[a][i] & out_lbl[b][i]) != out_lbl[b][i]) return;
      end
    end
    if (flag_tbl[a][rlf_pkg::FLAG_SOURCE]) begin
      h = in_lbl[a][0][7:0];
      if (!in_lbl[b][hash_slot(h)][h[4:0]]) return;
    end else begin
      for (int i = 0; i < rlf_pkg::LABEL_WORDS; i++) begin
        if ((in_lbl[a][i] & in_lbl[b][i]) != in_lbl[a][i]) return;
      end
    end
    v = rlf_pkg::V_UNDECIDED;
  endtask

  task automatic absorb_word(input rlf_pkg::in_word_t w);
    rlf_pkg::out_word_t res;
    int unsigned        n;
    int unsigned        idx;
    n = 32'(w.node_a);
    if (w.command == rlf_pkg::CMD_WRITE) begin
      case (w.record_field)
        rlf_pkg::FLD_DOWN:      lvl_down[n] = w.write_value[rlf_pkg::LVL_W-1:0];
        rlf_pkg::FLD_UP:        lvl_up[n] = w.write_value[rlf_pkg::LVL_W-1:0];
        rlf_pkg::FLD_MAX_OUT:   max_out_tbl[n] = w.write_value;
        rlf_pkg::FLD_IVL_START: ivl_lo[n] = w.write_value[rlf_pkg::LVL_W-1:0];
        rlf_pkg::FLD_IVL_END:   ivl_hi[n] = w.write_value[rlf_pkg::LVL_W-1:0];
        rlf_pkg::FLD_FLAGS:     flag_tbl[n] = w.write_value[rlf_pkg::FLAG_W-1:0];
        default: begin
          if (w.record_field < rlf_pkg::FLD_IN0) begin
            idx = 32'(w.record_field - rlf_pkg::FLD_OUT0);
            if (idx < rlf_pkg::LABEL_WORDS) out_lbl[n][idx] = w.write_value;
          end else begin
            idx = 32'(w.record_field - rlf_pkg::FLD_IN0);
            if (idx < rlf_pkg::LABEL_WORDS) in_lbl[n][idx] = w.write_value;
          end
        end
      endcase
    end else begin
      resolve_query(32'(w.node_a), 32'(w.node_b), res.verdict);
      res.filtered_total = rejected_total;
      verdict_q = {verdict_q, res};
    end
  endtask

  task automatic send_word(input rlf_pkg::in_word_t w);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_taken++;
    absorb_word(w);
  endtask

  task automatic put_field(input logic [11:0] node, input logic [3:0] fld,
                           input logic [31:0] value);
    rlf_pkg::in_word_t w;
    w.command      = rlf_pkg::CMD_WRITE;
    w.node_a       = node;
    w.node_b       = 12'($urandom);
    w.record_field = fld;
    w.write_value  = value;
    send_word(w);
  endtask

  task automatic ask(input logic [11:0] a, input logic [11:0] b);
    rlf_pkg::in_word_t w;
    w.command      = rlf_pkg::CMD_QUERY;
    w.node_a       = a;
    w.node_b       = b;
    w.record_field = 4'($urandom);
    w.write_value  = $urandom;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  function automatic logic [31:0] pad_lvl(input int unsigned v);
    return ($urandom & 32'hFFFF_E000) | (v & 32'h1FFF);
  endfunction

  function automatic logic [11:0] pick_node();
    return pool[$urandom_range(POOL_SIZE - 1, 0)];
  endfunction

  function automatic logic [7:0] hash_byte();
    if ($urandom_range(3, 0) == 0) return {3'($urandom_range(7, 5)), 5'($urandom)};
    return 8'($urandom);
  endfunction

  task automatic pass_filter(input logic [11:0] a, input logic [11:0] b, input bit extreme);
    int unsigned da, db, ua, ub, ea, eb;
    logic [31:0] ma, mb, t;
    da = $urandom_range(8190, 0);
    db = $urandom_range(8191, da + 1);
    ub = $urandom_range(8190, 0);
    ua = $urandom_range(8191, ub + 1);
    eb = $urandom_range(8191, 0);
    ea = $urandom_range(8191, eb);
    ma = $urandom;
    mb = $urandom;
    if ($signed(ma) < $signed(mb)) begin
      t = ma;
      ma = mb;
      mb = t;
    end
    if ($urandom_range(7, 0) == 0) ma = mb;
    if (extreme) begin
      da = 0;
      db = 8191;
      ub = 0;
      ua = 8191;
      eb = 0;
      ea = 8191;
      ma = 32'h7FFF_FFFF;
      mb = 32'h8000_0000;
    end
    put_field(a, rlf_pkg::FLD_DOWN, pad_lvl(da));
    put_field(b, rlf_pkg::FLD_DOWN, pad_lvl(db));
    put_field(a, rlf_pkg::FLD_UP, pad_lvl(ua));
    put_field(b, rlf_pkg::FLD_UP, pad_lvl(ub));
    put_field(a, rlf_pkg::FLD_MAX_OUT, ma);
    put_field(b, rlf_pkg::FLD_MAX_OUT, mb);
    put_field(a, rlf_pkg::FLD_IVL_END, pad_lvl(ea));
    put_field(b, rlf_pkg::FLD_IVL_END, pad_lvl(eb));
  endtask

  task automatic filter_break(input logic [11:0] a, input logic [11:0] b,
                              input int unsigned which);
    logic [31:0] ma, mb, t;
    int unsigned eb;
    pass_filter(a, b, 1'b0);
    case (which)
      0: put_field(a, rlf_pkg::FLD_DOWN, pad_lvl($urandom_range(8191, 32'(lvl_down[b]))));
      1: put_field(a, rlf_pkg::FLD_UP, pad_lvl($urandom_range(32'(lvl_up[b]), 0)));
      2: begin
        ma = $urandom;
        mb = $urandom;
        if ($signed(ma) > $signed(mb)) begin
          t = ma;
          ma = mb;
          mb = t;
        end
        if (ma == mb) begin
          ma = 32'h8000_0000;
          mb = 32'h7FFF_FFFF;
        end
        put_field(a, rlf_pkg::FLD_MAX_OUT, ma);
        put_field(b, rlf_pkg::FLD_MAX_OUT, mb);
      end
      default: begin
        eb = $urandom_range(8191, 1);
        put_field(b, rlf_pkg::FLD_IVL_END, pad_lvl(eb));
        put_field(a, rlf_pkg::FLD_IVL_END, pad_lvl($urandom_range(eb - 1, 0)));
      end
    endcase
    ask(a, b);
  endtask

  // Builds a pair that gets past the filter, then shapes flags and label words so
  // that each later test passes most of the time and fails now and then.
  task automatic deep_query(input logic [11:0] a, input logic [11:0] b, input bit start_hit);
    int unsigned sa, sb, slot, brk, j;
    logic [1:0]  fa, fb;
    logic [7:0]  h;
    logic [31:0] la, lb;
    bit          keep;
    pass_filter(a, b, $urandom_range(15, 0) == 0);
    if (start_hit) begin
      sb = $urandom_range(8191, 0);
      sa = $urandom_range(sb, 0);
    end else begin
      sb = $urandom_range(8190, 0);
      sa = $urandom_range(8191, sb + 1);
    end
    put_field(a, rlf_pkg::FLD_IVL_START, pad_lvl(sa));
    put_field(b, rlf_pkg::FLD_IVL_START, pad_lvl(sb));
    if (start_hit) begin
      ask(a, b);
      return;
    end
    fa = 2'($urandom);
    fb = 2'($urandom);
    if ($urandom_range(3, 0) != 0) begin
      fa[rlf_pkg::FLAG_SINK]   = 1'b0;
      fb[rlf_pkg::FLAG_SOURCE] = 1'b0;
    end
    put_field(a, rlf_pkg::FLD_FLAGS, ($urandom & 32'hFFFF_FFFC) | 32'(fa));
    put_field(b, rlf_pkg::FLD_FLAGS, ($urandom & 32'hFFFF_FFFC) | 32'(fb));
    keep = $urandom_range(3, 0) != 0;
    if (fb[rlf_pkg::FLAG_SINK]) begin
      h = hash_byte();
      put_field(b, rlf_pkg::FLD_OUT0, ($urandom & 32'hFFFF_FF00) | 32'(h));
      slot = hash_slot(h);
      la = $urandom;
      la[h[4:0]] = keep;
      put_field(a, 4'(32'(rlf_pkg::FLD_OUT0) + slot), la);
    end else begin
      brk = $urandom_range(rlf_pkg::LABEL_WORDS - 1, 0);
      j = $urandom_range(31, 0);
      for (int i = 0; i < rlf_pkg::LABEL_WORDS; i++) begin
        lb = $urandom & $urandom & $urandom;
        la = lb | $urandom;
        if (!keep && i == brk) begin
          lb[j] = 1'b1;
          la[j] = 1'b0;
        end
        put_field(b, 4'(32'(rlf_pkg::FLD_OUT0) + i), lb);
        put_field(a, 4'(32'(rlf_pkg::FLD_OUT0) + i), la);
      end
    end
    keep = $urandom_range(3, 0) != 0;
    if (fa[rlf_pkg::FLAG_SOURCE]) begin
      h = hash_byte();
      put_field(a, rlf_pkg::FLD_IN0, ($urandom & 32'hFFFF_FF00) | 32'(h));
      slot = hash_slot(h);
      lb = $urandom;
      lb[h[4:0]] = keep;
      put_field(b, 4'(32'(rlf_pkg::FLD_IN0) + slot), lb);
    end else begin
      brk = $urandom_range(rlf_pkg::LABEL_WORDS - 1, 0);
      j = $urandom_range(31, 0);
      for (int i = 0; i < rlf_pkg::LABEL_WORDS; i++) begin
        la = $urandom & $urandom & $urandom;
        lb = la | $urandom;
        if (!keep && i == brk) begin
          la[j] = 1'b1;
          lb[j] = 1'b0;
        end
        put_field(a, 4'(32'(rlf_pkg::FLD_IN0) + i), la);
        put_field(b, 4'(32'(rlf_pkg::FLD_IN0) + i), lb);
      end
    end
    ask(a, b);
  endtask

  task automatic random_step();
    logic [11:0] a, b;
    a = pick_node();
    b = pick_node();
    while (b == a) b = pick_node();
    case ($urandom_range(9, 0))
      0:       ask(a, a);
      1, 2:    ask(a, b);
      3:       put_field(pick_node(), 4'($urandom), $urandom);
      4:       filter_break(a, b, $urandom_range(3, 0));
      5:       deep_query(a, b, 1'b1);
      default: deep_query(a, b, 1'b0);
    endcase
  endtask

  // Every node that a query may touch gets all of its fields written first.
  task automatic test_load_records();
    pool[0] = 12'h000;
    pool[1] = 12'hFFF;
    pool[2] = 12'hAAA;
    pool[3] = 12'h555;
    for (int i = 4; i < POOL_SIZE; i++) pool[i] = 12'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) begin
      for (int f = 0; f < 16; f++) put_field(pool[i], 4'(f), $urandom);
    end
  endtask

  task automatic test_self_queries();
    ask(12'h000, 12'h000);
    ask(12'hFFF, 12'hFFF);
    ask(12'hAAA, 12'hAAA);
  endtask

  task automatic test_extremes();
    pass_filter(12'h000, 12'hFFF, 1'b1);
    put_field(12'h000, rlf_pkg::FLD_IVL_START, 32'hFFFF_FFFF);
    put_field(12'hFFF, rlf_pkg::FLD_IVL_START, 32'h0000_0000);
    put_field(12'h000, rlf_pkg::FLD_FLAGS, 32'hFFFF_FFFC);
    put_field(12'hFFF, rlf_pkg::FLD_FLAGS, 32'hFFFF_FFFE);
    put_field(12'hFFF, rlf_pkg::FLD_OUT0, 32'h0000_00FF);
    put_field(12'h000, 4'(32'(rlf_pkg::FLD_OUT0) + hash_slot(8'hFF)), 32'h8000_0000);
    ask(12'h000, 12'hFFF);
    ask(12'hFFF, 12'h000);
    put_field(12'h000, rlf_pkg::FLD_MAX_OUT, 32'h8000_0000);
    ask(12'h000, 12'hFFF);
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned hold_pct,
                                   input int unsigned goal);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    while (words_taken < goal) random_step();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        verdict_head = verdict_q.pop_front();
        if (out_data.verdict !== verdict_head.verdict)
          report_mismatch($sformatf("verdict %0d, predicted %0d",
                                    out_data.verdict, verdict_head.verdict));
        if (out_data.filtered_total !== verdict_head.filtered_total)
          report_mismatch($sformatf("filtered total %0d, predicted %0d",
                                    out_data.filtered_total, verdict_head.filtered_total));
      end
    end
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_load_records();
    test_self_queries();
    test_extremes();
    wait_drained();
    test_random_phase(0, 0, 700);
    test_random_phase(70, 0, 1000);
    wait_drained();
    test_random_phase(0, 70, 1300);
    test_random_phase(33, 33, 1600);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== reachability_label_filter_unit.f =====
rtl/rlf_pkg.sv
rtl/rlf_ram.sv
rtl/rlf_cmp.sv
rtl/reachability_label_filter_unit.sv
sim/tb_reachability_label_filter_unit.sv
